>>> sv/fsra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsra_pkg;

  localparam int HANDLE_W = 8;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TRY   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_REUSED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CREATED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic load_item;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic result_busy;
  } ctrl_status_t;

endpackage

`default_nettype wire

>>> sv/fifo_reuse_slot_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Slot allocator with a first-in first-out free list.
// Input stream (s_*): one command per transfer. s_tuser carries the command
// (allocate, try allocate, deallocate), s_tdata the handle to free.
// Output stream (m_*): exactly one result per command. m_tdata carries the
// granted slot (zero when none is granted), m_tuser the status.
// Timing: a command is taken in the idle state and executed in the execute
// state; the result is valid on m_* the cycle after execution. The execute
// state is there for the registered read port of the free queue memory,
// which is read at the head before the command executes.
// A waiting result does not block the next transfer in; if a result is still
// waiting when the next command executes, execution holds until m_tready.
// Reset (synchronous) clears the in-use bitmap, empties the queue and the
// creation counter, and drops any pending result. Slots are created up to
// min(POOL_SLOTS, 256); after that allocate reports none on an empty queue.
module fifo_reuse_slot_allocator_unit
  import fsra_pkg::*;
#(
  parameter int POOL_SLOTS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] slot_handle
  input  wire logic [1:0]  s_tuser,   // [1:0] command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] granted_slot
  output logic [1:0]       m_tuser    // [1:0] status
);

  localparam int SLOT_LIMIT = (POOL_SLOTS < 256) ? POOL_SLOTS : 256;

  ctrl_cmd_t    ctl_cmd;
  ctrl_status_t ctl_status;

  fsra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (ctl_status),
    .cmd      (ctl_cmd)
  );

  fsra_datapath #(
    .SLOT_LIMIT (SLOT_LIMIT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (ctl_cmd),
    .status     (ctl_status),
    .in_command (s_tuser),
    .in_handle  (s_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_slot   (m_tdata),
    .out_status (m_tuser)
  );

endmodule

`default_nettype wire

>>> sv/fsra_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fsra_ctrl
  import fsra_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire ctrl_status_t status,
  output ctrl_cmd_t         cmd
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;

  always_comb begin
    in_ready      = (state == IDLE);
    cmd.load_item = (state == IDLE) && in_valid;
    // hold in execute until the result register can take the new result
    cmd.commit    = (state == EXEC) && !status.result_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) state <= EXEC;
        end
        EXEC: begin
          if (!status.result_busy) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/fsra_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module fsra_datapath
  import fsra_pkg::*;
#(
  parameter int SLOT_LIMIT = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctrl_cmd_t           cmd,
  output ctrl_status_t             status,
  input  wire logic [CMD_W-1:0]    in_command,
  input  wire logic [HANDLE_W-1:0] in_handle,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [HANDLE_W-1:0]      out_slot,
  output logic [STATUS_W-1:0]      out_status
);

  localparam int IW = $clog2(SLOT_LIMIT);
  localparam int CW = $clog2(SLOT_LIMIT + 1);
  localparam logic [IW-1:0] LAST_POS = IW'(SLOT_LIMIT - 1);
  localparam logic [CW-1:0] LIMIT_CNT = CW'(SLOT_LIMIT);

  logic [CMD_W-1:0]    item_cmd;
  logic [HANDLE_W-1:0] item_handle;

  logic [SLOT_LIMIT-1:0] slot_in_use;
  logic [IW-1:0]         free_queue [SLOT_LIMIT];
  logic [IW-1:0]         queue_rd;
  logic [IW-1:0]         queue_head;
  logic [IW-1:0]         queue_tail;
  logic [CW-1:0]         queue_count;
  logic [CW-1:0]         slots_created;

  logic                handle_ok;
  logic [IW-1:0]       handle_idx;
  logic                do_pop;
  logic                do_create;
  logic                do_push;
  logic [HANDLE_W-1:0] res_slot;
  logic [STATUS_W-1:0] res_status;

  assign status.result_busy = out_valid && !out_ready;

  assign handle_idx = item_handle[IW-1:0];
  assign handle_ok  = (32'(item_handle) < 32'(SLOT_LIMIT)) && slot_in_use[handle_idx];

  always_comb begin
    do_pop     = 1'b0;
    do_create  = 1'b0;
    do_push    = 1'b0;
    res_slot   = '0;
    res_status = ST_INVALID;
    case (item_cmd)
      CMD_ALLOC, CMD_TRY: begin
        if (queue_count != '0) begin
          do_pop     = 1'b1;
          res_slot   = HANDLE_W'(queue_rd);
          res_status = ST_REUSED;
        end else if (item_cmd == CMD_ALLOC && slots_created < LIMIT_CNT) begin
          do_create  = 1'b1;
          res_slot   = HANDLE_W'(slots_created);
          res_status = ST_CREATED;
        end else begin
          res_status = ST_NONE;
        end
      end
      CMD_FREE: begin
        if (handle_ok) begin
          do_push    = 1'b1;
          res_status = ST_REUSED;
        end
      end
      default: res_status = ST_INVALID;
    endcase
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd    <= in_command;
      item_handle <= in_handle;
    end
  end

  // free queue memory: registered read at head, write at tail
  always_ff @(posedge clk) begin
    queue_rd <= free_queue[queue_head];
    if (cmd.commit && do_push) free_queue[queue_tail] <= handle_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_in_use   <= '0;
      queue_head    <= '0;
      queue_tail    <= '0;
      queue_count   <= '0;
      slots_created <= '0;
    end else if (cmd.commit) begin
      if (do_pop) begin
        slot_in_use[queue_rd] <= 1'b1;
        queue_head  <= (queue_head == LAST_POS) ? '0 : queue_head + 1'b1;
        queue_count <= queue_count - 1'b1;
      end
      if (do_create) begin
        slot_in_use[slots_created[IW-1:0]] <= 1'b1;
        slots_created <= slots_created + 1'b1;
      end
      if (do_push) begin
        slot_in_use[handle_idx] <= 1'b0;
        queue_tail  <= (queue_tail == LAST_POS) ? '0 : queue_tail + 1'b1;
        queue_count <= queue_count + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_slot   <= res_slot;
      out_status <= res_status;
    end
  end

endmodule

`default_nettype wire
